// ===== hdl/tru_pkg.sv =====
// Shared types and constants of the triangular rank-one update block.
// Used by every module of the block but tru_mul; depends on nothing.
package tru_pkg;

   localparam int TRU_MAX_DIM     = 16;
   localparam int TRU_VALUE_BITS  = 32;
   localparam int TRU_FIELD_BITS  = 32;
   localparam int TRU_IDX_BITS    = 4;
   localparam int TRU_COUNT_BITS  = 5;
   localparam int TRU_OP_BITS     = 3;
   localparam int TRU_CSR_BITS    = 2;
   localparam int TRU_ALPHA_RESET = 65536;
   localparam int TRU_COUNT_RESET = 16;

   typedef enum logic [TRU_OP_BITS-1:0] {
      OP_WRITE_X = 3'd0,
      OP_WRITE_Y = 3'd1,
      OP_WRITE_A = 3'd2,
      OP_RUN     = 3'd3,
      OP_READ    = 3'd4
   } tru_op_type;

   typedef enum logic [TRU_CSR_BITS-1:0] {
      CSR_ALPHA = 2'd0,
      CSR_UPPER = 2'd1,
      CSR_ROWS  = 2'd2,
      CSR_COLS  = 2'd3
   } tru_csr_type;

   localparam logic RK_READ   = 1'b0;
   localparam logic RK_FINISH = 1'b1;

   typedef struct packed {
      logic [TRU_OP_BITS-1:0]           req_type;
      logic [TRU_IDX_BITS-1:0]          row_index;
      logic [TRU_IDX_BITS-1:0]          col_index;
      logic signed [TRU_FIELD_BITS-1:0] data_value;
   } tru_req_item_type;

   typedef struct packed {
      logic                             result_kind;
      logic signed [TRU_FIELD_BITS-1:0] entry_value;
      logic                             saturated;
   } tru_rsp_item_type;

   typedef struct packed {
      logic take;
      logic clr_sat;
      logic y_rd;
      logic col_mul_go;
      logic cap_t;
      logic ent_rd;
      logic ent_mul_go;
      logic ent_wr;
      logic rsp_finish;
   } tru_cmd_type;

   typedef struct packed {
      logic                      mul_done;
      logic                      upper;
      logic [TRU_COUNT_BITS-1:0] row_count;
      logic [TRU_COUNT_BITS-1:0] col_count;
   } tru_status_type;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_RD_OUT   = 9'b000000010,
      S_COL_RD   = 9'b000000100,
      S_COL_MUL  = 9'b000001000,
      S_COL_WAIT = 9'b000010000,
      S_ROW_CHK  = 9'b000100000,
      S_ENT_MUL  = 9'b001000000,
      S_ENT_WAIT = 9'b010000000,
      S_FINISH   = 9'b100000000
   } tru_state_type;

endpackage

// ===== hdl/triangular_rank1_update.sv =====
// Top level of the triangular rank-one update block.
// Depends on tru_pkg, tru_ctrl and tru_dpath.
//
// Usage:
//   A request beat is taken when start is high and busy is low. Types load
//   x, y or one entry of A, start an update run, or read one entry of A.
//   Loads leave busy low. A read raises busy for one cycle and presents
//   its result on rsp_item with rsp_valid high in the cycle after the
//   request; no new request is taken before that result.
//   A run walks column j over N columns and row i over the rows inside the
//   selected triangle. Per column it reads y[j], forms alpha*y[j] on the
//   shared iterative multiplier and keeps it; per entry it reads A and x[i],
//   multiplies x[i] by that value and writes back the saturating sum. The
//   multiplier works in D = ceil(max(VALUE_BITS,18)/16) 16-bit digit steps
//   (D = 2 at 32 bits). The finish beat comes in the cycle after the last
//   column, or in the cycle after the request when N is zero.
//   Results are strobed for exactly one cycle; the receiver cannot stall
//   them and no result waits.
//   The csr channel is always ready and may be written while busy is low.
//   Reset idles the controller, loads the configuration registers with their
//   reset values and clears the saturation flag; x, y and A hold nothing defined until loaded.
module triangular_rank1_update #(
   parameter int MAX_DIM    = tru_pkg::TRU_MAX_DIM,
   parameter int VALUE_BITS = tru_pkg::TRU_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tru_pkg::tru_req_item_type          req_item,
   output logic                               rsp_valid,
   output tru_pkg::tru_rsp_item_type          rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tru_pkg::TRU_CSR_BITS-1:0]   csr_index,
   input  logic [tru_pkg::TRU_FIELD_BITS-1:0] csr_data
);
   import tru_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);

   tru_cmd_type      cmd;
   tru_status_type   status;
   logic [IDX_W-1:0] run_row, run_col;

   assign csr_ready = 1'b1;

   tru_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_item.req_type),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .run_row   (run_row),
      .run_col   (run_col)
   );

   tru_dpath #(
      .MAX_DIM    (MAX_DIM),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .run_row   (run_row),
      .run_col   (run_col),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== hdl/tru_mul.sv =====
// Iterative saturating fixed-point multiplier, one 16-bit digit per cycle.
// Product is shifted right by 16 toward zero and clamped; stand-alone.
module tru_mul #(
   parameter int OPW = 32,
   parameter int VB  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic signed [OPW-1:0] op_a,
   input  logic signed [OPW-1:0] op_b,
   output logic                  done,
   output logic signed [VB-1:0]  prod,
   output logic                  sat
);

   localparam int DIGITS = (OPW + 15) / 16;
   localparam int BW     = 16 * DIGITS;
   localparam int ACCW   = OPW + BW;
   localparam int SHW    = ACCW - 16;
   localparam int PW     = OPW + 16;
   localparam int CW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [SHW-1:0] LIM_POS = (SHW'(1) << (VB - 1)) - SHW'(1);
   localparam logic [SHW-1:0] LIM_NEG = SHW'(1) << (VB - 1);

   logic                 run_ff, run_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [OPW-1:0]       mag_a_ff, mag_a_in;
   logic [BW-1:0]        mag_b_ff, mag_b_in;
   logic [ACCW-1:0]      acc_ff, acc_in;
   logic signed [VB-1:0] prod_ff, prod_in;
   logic                 sat_ff, sat_in;

   logic [OPW-1:0]  a_u, b_u, a_mag, b_mag;
   logic [PW-1:0]   part;
   logic [ACCW-1:0] acc_next;
   logic [SHW-1:0]  shifted, lim;
   logic            ovf;
   logic [VB-1:0]   mag_v;

   always_comb begin
      a_u      = op_a;
      b_u      = op_b;
      a_mag    = a_u[OPW-1] ? (~a_u + OPW'(1)) : a_u;
      b_mag    = b_u[OPW-1] ? (~b_u + OPW'(1)) : b_u;
      part     = PW'(mag_a_ff) * PW'(mag_b_ff[BW-1 -: 16]);
      acc_next = (acc_ff << 16) + ACCW'(part);
      shifted  = acc_ff[ACCW-1:16];
      lim      = neg_ff ? LIM_NEG : LIM_POS;
      ovf      = shifted > lim;
      mag_v    = ovf ? lim[VB-1:0] : shifted[VB-1:0];
   end

   always_comb begin
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      fin_in   = run_ff && (cnt_ff == '0);
      done_in  = fin_ff;
      neg_in   = neg_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      sat_in   = sat_ff;
      if (go) begin
         run_in   = 1'b1;
         cnt_in   = CW'(DIGITS - 1);
         neg_in   = a_u[OPW-1] ^ b_u[OPW-1];
         mag_a_in = a_mag;
         mag_b_in = BW'(b_mag);
         acc_in   = '0;
      end else if (run_ff) begin
         acc_in   = acc_next;
         mag_b_in = mag_b_ff << 16;
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
      if (fin_ff) begin
         prod_in = neg_ff ? (~mag_v + VB'(1)) : mag_v;
         sat_in  = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      sat_ff   <= sat_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
   assign sat  = sat_ff;

endmodule

// ===== hdl/tru_dpath.sv =====
// Datapath: configuration registers, x/y/matrix memories, multiplier and
// saturating adder. Depends on tru_pkg and tru_mul.
module tru_dpath #(
   parameter int MAX_DIM    = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tru_pkg::tru_req_item_type        req_item,
   input  tru_pkg::tru_cmd_type             cmd,
   input  logic [$clog2(MAX_DIM)-1:0]       run_row,
   input  logic [$clog2(MAX_DIM)-1:0]       run_col,
   input  logic                             csr_wr,
   input  logic [tru_pkg::TRU_CSR_BITS-1:0] csr_index,
   input  logic [tru_pkg::TRU_FIELD_BITS-1:0] csr_data,
   output tru_pkg::tru_status_type          status,
   output tru_pkg::tru_rsp_item_type        rsp_item
);
   import tru_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int VB    = VALUE_BITS;
   localparam int OPW   = (VB >= 18) ? VB : 18;
   localparam int XW    = (VB > 32) ? VB : 32;
   localparam int SW    = VB + 1;
   localparam logic signed [XW-1:0] VMAX_X = XW'({1'b0, {(VB - 1){1'b1}}});
   localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
   localparam logic signed [XW-1:0] RMAX_X = XW'({1'b0, {31{1'b1}}});
   localparam logic signed [XW-1:0] RMIN_X = ~RMAX_X;
   localparam logic signed [SW-1:0] VMAX_S = SW'({1'b0, {(VB - 1){1'b1}}});
   localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;

   function automatic logic signed [VB-1:0] clamp_in(input logic signed [31:0] d);
      logic signed [XW-1:0] w;
      w = XW'(d);
      if (w > VMAX_X) begin
         w = VMAX_X;
      end else if (w < VMIN_X) begin
         w = VMIN_X;
      end
      return VB'(w);
   endfunction

   logic signed [VB-1:0] mat_mem [DEPTH];
   logic signed [VB-1:0] x_mem [MAX_DIM];
   logic signed [VB-1:0] y_mem [MAX_DIM];

   logic signed [OPW-1:0] alpha_ff, alpha_in;
   logic                  upper_ff, upper_in;
   logic [TRU_COUNT_BITS-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic                  satf_ff, satf_in;
   logic signed [VB-1:0]  t_ff, t_in;
   logic                  oob_ff, oob_in;
   logic signed [VB-1:0]  mat_rd_ff, x_rd_ff, y_rd_ff;

   logic                  row_ok, col_ok;
   logic [IDX_W-1:0]      req_row, req_col;
   logic [AW-1:0]         req_addr, run_addr, mat_waddr, mat_raddr;
   logic signed [VB-1:0]  data_v, mat_wdata, sum_v;
   logic signed [SW-1:0]  sum_w;
   logic                  add_ovf;
   logic                  mat_we, mat_re, x_we, y_we;
   logic                  mul_go, mul_done, mul_sat;
   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [VB-1:0]  mul_prod;
   logic signed [XW-1:0]  rd_w;
   logic signed [31:0]    rd_v;

   always_comb begin
      row_ok   = 32'(req_item.row_index) < MAX_DIM;
      col_ok   = 32'(req_item.col_index) < MAX_DIM;
      req_row  = IDX_W'(req_item.row_index);
      req_col  = IDX_W'(req_item.col_index);
      req_addr = AW'(req_row * MAX_DIM + req_col);
      run_addr = AW'(run_row * MAX_DIM + run_col);
      data_v   = clamp_in(req_item.data_value);

      sum_w   = SW'(mat_rd_ff) + SW'(mul_prod);
      add_ovf = (sum_w > VMAX_S) || (sum_w < VMIN_S);
      if (sum_w > VMAX_S) begin
         sum_v = VB'(VMAX_S);
      end else if (sum_w < VMIN_S) begin
         sum_v = VB'(VMIN_S);
      end else begin
         sum_v = VB'(sum_w);
      end

      x_we      = cmd.take && (req_item.req_type == OP_WRITE_X) && row_ok;
      y_we      = cmd.take && (req_item.req_type == OP_WRITE_Y) && col_ok;
      mat_we    = (cmd.take && (req_item.req_type == OP_WRITE_A) && row_ok && col_ok)
                  || cmd.ent_wr;
      mat_re    = (cmd.take && (req_item.req_type == OP_READ) && row_ok && col_ok)
                  || cmd.ent_rd;
      mat_waddr = cmd.ent_wr ? run_addr : req_addr;
      mat_wdata = cmd.ent_wr ? sum_v : data_v;
      mat_raddr = cmd.ent_rd ? run_addr : req_addr;

      mul_go = cmd.col_mul_go || cmd.ent_mul_go;
      mul_a  = cmd.col_mul_go ? alpha_ff : OPW'(x_rd_ff);
      mul_b  = cmd.col_mul_go ? OPW'(y_rd_ff) : OPW'(t_ff);
   end

   always_comb begin
      alpha_in = alpha_ff;
      upper_in = upper_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_in = OPW'(clamp_in(csr_data));
            CSR_UPPER: upper_in = csr_data[0];
            CSR_ROWS:  rows_in  = csr_data[TRU_COUNT_BITS-1:0];
            CSR_COLS:  cols_in  = csr_data[TRU_COUNT_BITS-1:0];
         endcase
      end
      satf_in = satf_ff;
      if (cmd.clr_sat) begin
         satf_in = 1'b0;
      end else if ((mul_done && mul_sat) || (cmd.ent_wr && add_ovf)) begin
         satf_in = 1'b1;
      end
      t_in   = cmd.cap_t ? mul_prod : t_ff;
      oob_in = (cmd.take && (req_item.req_type == OP_READ)) ? !(row_ok && col_ok) : oob_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= OPW'(TRU_ALPHA_RESET);
         upper_ff <= 1'b0;
         rows_ff  <= TRU_COUNT_BITS'(TRU_COUNT_RESET);
         cols_ff  <= TRU_COUNT_BITS'(TRU_COUNT_RESET);
         satf_ff  <= 1'b0;
      end else begin
         alpha_ff <= alpha_in;
         upper_ff <= upper_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         satf_ff  <= satf_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      oob_ff <= oob_in;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      if (mat_re) begin
         mat_rd_ff <= mat_mem[mat_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[req_row] <= data_v;
      end
      if (cmd.ent_rd) begin
         x_rd_ff <= x_mem[run_row];
      end
   end

   always_ff @(posedge clock) begin
      if (y_we) begin
         y_mem[req_col] <= data_v;
      end
      if (cmd.y_rd) begin
         y_rd_ff <= y_mem[run_col];
      end
   end

   tru_mul #(
      .OPW (OPW),
      .VB  (VB)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod),
      .sat   (mul_sat)
   );

   always_comb begin
      rd_w = XW'(mat_rd_ff);
      if (rd_w > RMAX_X) begin
         rd_w = RMAX_X;
      end else if (rd_w < RMIN_X) begin
         rd_w = RMIN_X;
      end
      rd_v = 32'(rd_w);

      status.mul_done  = mul_done;
      status.upper     = upper_ff;
      status.row_count = rows_ff;
      status.col_count = cols_ff;

      rsp_item.result_kind = cmd.rsp_finish ? RK_FINISH : RK_READ;
      rsp_item.entry_value = (cmd.rsp_finish || oob_ff) ? '0 : rd_v;
      rsp_item.saturated   = satf_ff;
   end

endmodule

// ===== hdl/tru_ctrl.sv =====
// Controller: request decode and the column/row sequencer of an update run.
// Depends on tru_pkg; drives tru_dpath through command and status structs.
module tru_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tru_pkg::TRU_OP_BITS-1:0] req_op,
   input  tru_pkg::tru_status_type         status,
   output logic                            busy,
   output logic                            rsp_valid,
   output tru_pkg::tru_cmd_type            cmd,
   output logic [$clog2(MAX_DIM)-1:0]      run_row,
   output logic [$clog2(MAX_DIM)-1:0]      run_col
);
   import tru_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CNT_W = $clog2(MAX_DIM + 1);

   tru_state_type state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] m_eff, n_eff;
   logic             row_go;

   always_comb begin
      m_eff = (32'(status.row_count) > MAX_DIM) ? CNT_W'(MAX_DIM)
                                                : CNT_W'(status.row_count);
      n_eff = (32'(status.col_count) > MAX_DIM) ? CNT_W'(MAX_DIM)
                                                : CNT_W'(status.col_count);
      row_go = (i_ff < m_eff) && (!status.upper || (i_ff <= j_ff));
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.take = 1'b1;
               if (req_op == OP_RUN) begin
                  cmd.clr_sat = 1'b1;
                  j_in        = '0;
                  state_in    = (n_eff == '0) ? S_FINISH : S_COL_RD;
               end else if (req_op == OP_READ) begin
                  state_in = S_RD_OUT;
               end
            end
         end
         S_RD_OUT: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         S_COL_RD: begin
            cmd.y_rd = 1'b1;
            state_in = S_COL_MUL;
         end
         S_COL_MUL: begin
            cmd.col_mul_go = 1'b1;
            state_in       = S_COL_WAIT;
         end
         S_COL_WAIT: begin
            if (status.mul_done) begin
               cmd.cap_t = 1'b1;
               i_in      = status.upper ? '0 : j_ff;
               state_in  = S_ROW_CHK;
            end
         end
         S_ROW_CHK: begin
            if (row_go) begin
               cmd.ent_rd = 1'b1;
               state_in   = S_ENT_MUL;
            end else if ((j_ff + CNT_W'(1)) >= n_eff) begin
               state_in = S_FINISH;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_COL_RD;
            end
         end
         S_ENT_MUL: begin
            cmd.ent_mul_go = 1'b1;
            state_in       = S_ENT_WAIT;
         end
         S_ENT_WAIT: begin
            if (status.mul_done) begin
               cmd.ent_wr = 1'b1;
               i_in       = i_ff + CNT_W'(1);
               state_in   = S_ROW_CHK;
            end
         end
         S_FINISH: begin
            cmd.rsp_finish = 1'b1;
            rsp_valid      = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign busy    = (state_ff != S_IDLE);
   assign run_row = IDX_W'(i_ff);
   assign run_col = IDX_W'(j_ff);

endmodule

// ===== hdl/tru_chk.sv =====
// Port-level checker for triangular_rank1_update, bound to the top level.
// Depends on tru_pkg.
module tru_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input tru_pkg::tru_req_item_type req_item,
   input logic                      rsp_valid,
   input tru_pkg::tru_rsp_item_type rsp_item
);
   import tru_pkg::*;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_read_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type == OP_READ))
      |=> (rsp_valid && (rsp_item.result_kind == RK_READ)))
      else $error("read beat did not answer in the next cycle");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_item.req_type == OP_WRITE_X) ||
                          (req_item.req_type == OP_WRITE_Y) ||
                          (req_item.req_type == OP_WRITE_A)))
      |=> (!busy && !rsp_valid))
      else $error("load beat left the block busy");

   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.result_kind == RK_FINISH)) |-> (rsp_item.entry_value == '0))
      else $error("finish beat with nonzero entry value");

endmodule

bind triangular_rank1_update tru_chk u_tru_chk (.*);

// ===== tb/triangular_rank1_update_tb.sv =====
// Testbench for triangular_rank1_update: a directed table, register sweeps and random
// request traffic, every result beat checked against a fixed-point predictor or the
// table's own value. Depends on tru_pkg and the triangular_rank1_update RTL.
module triangular_rank1_update_tb;
   import tru_pkg::*;

   localparam int DIM         = TRU_MAX_DIM;
   localparam int STALL_LIMIT = 20000;
   localparam int MAX_SHOWN   = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 160;
   localparam int SETTLE      = 8;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
   localparam logic [31:0] Q_ONE     = 32'h0001_0000;
   localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
   localparam logic [31:0] Q_TOP     = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_BOTTOM  = 32'h8000_0000;

   localparam logic [TRU_OP_BITS-1:0] OP_RSVD_LO  = 3'd5;
   localparam logic [TRU_OP_BITS-1:0] OP_RSVD_MID = 3'd6;
   localparam logic [TRU_OP_BITS-1:0] OP_RSVD_HI  = 3'd7;

   typedef struct {
      bit               is_csr;
      tru_csr_type      csr_sel;
      logic [31:0]      csr_val;
      tru_req_item_type req;
      bit               has_want;
      tru_rsp_item_type want;
   } stim_row_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       busy;
   tru_req_item_type           req_item  = '0;
   logic                       rsp_valid;
   tru_rsp_item_type           rsp_item;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [TRU_CSR_BITS-1:0]    csr_index = '0;
   logic [TRU_FIELD_BITS-1:0]  csr_data  = '0;

   // predicted block state
   longint      a_mem [DIM*DIM];
   longint      x_mem [DIM];
   longint      y_mem [DIM];
   longint      cfg_alpha;
   bit          cfg_upper;
   logic [4:0]  cfg_rows;
   logic [4:0]  cfg_cols;
   bit          sat_seen;
   bit          sweep_sat;

   tru_rsp_item_type awaited_rsp [$];

   int mismatches   = 0;
   int n_reads      = 0;
   int n_runs       = 0;
   int n_beats      = 0;
   int n_csr        = 0;
   int idle_pct     = 16;
   int stall_cycles = 0;

   triangular_rank1_update dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint q16_mul(longint a, longint b);
      longint prod;
      longint mag;
      longint lim;
      prod = a * b;
      mag  = (prod < 0) ? -prod : prod;
      mag  = mag >> 16;
      lim  = (prod < 0) ? -Q_MIN : Q_MAX;
      if (mag > lim) begin
         sweep_sat = 1'b1;
         mag = lim;
      end
      return (prod < 0) ? -mag : mag;
   endfunction

   function automatic longint q16_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > Q_MAX) begin
         sweep_sat = 1'b1;
         s = Q_MAX;
      end else if (s < Q_MIN) begin
         sweep_sat = 1'b1;
         s = Q_MIN;
      end
      return s;
   endfunction

   function automatic void rank1_sweep();
      int     m;
      int     n;
      int     i;
      int     j;
      longint t;
      m = (cfg_rows > DIM) ? DIM : cfg_rows;
      n = (cfg_cols > DIM) ? DIM : cfg_cols;
      sweep_sat = 1'b0;
      for (j = 0; j < n; j++) begin
         t = q16_mul(cfg_alpha, y_mem[j]);
         for (i = 0; i < m; i++) begin
            if (cfg_upper ? (i <= j) : (i >= j)) begin
               a_mem[i*DIM+j] = q16_add(a_mem[i*DIM+j], q16_mul(x_mem[i], t));
            end
         end
      end
      sat_seen = sweep_sat;
   endfunction

   function automatic bit step_request(input tru_req_item_type it,
                                       output tru_rsp_item_type res);
      longint val;
      int     ri;
      int     ci;
      bit     has_res;
      val     = longint'($signed(it.data_value));
      ri      = it.row_index;
      ci      = it.col_index;
      res     = '0;
      has_res = 1'b0;
      case (it.req_type)
         OP_WRITE_X: x_mem[ri] = val;
         OP_WRITE_Y: y_mem[ci] = val;
         OP_WRITE_A: a_mem[ri*DIM+ci] = val;
         OP_RUN: begin
            rank1_sweep();
            res.result_kind = RK_FINISH;
            res.saturated   = sat_seen;
            has_res         = 1'b1;
         end
         OP_READ: begin
            res.result_kind = RK_READ;
            res.entry_value = 32'(a_mem[ri*DIM+ci]);
            res.saturated   = sat_seen;
            has_res         = 1'b1;
         end
         default: has_res = 1'b0;
      endcase
      return has_res;
   endfunction

   function automatic tru_req_item_type make_req(logic [TRU_OP_BITS-1:0] op, int r, int c,
                                                 logic [31:0] d);
      tru_req_item_type it;
      it.req_type   = op;
      it.row_index  = 4'(r);
      it.col_index  = 4'(c);
      it.data_value = d;
      return it;
   endfunction

   function automatic stim_row_type req_row(logic [TRU_OP_BITS-1:0] op, int r, int c,
                                            logic [31:0] d);
      stim_row_type row;
      row.is_csr   = 1'b0;
      row.csr_sel  = CSR_ALPHA;
      row.csr_val  = '0;
      row.req      = make_req(op, r, c, d);
      row.has_want = 1'b0;
      row.want     = '0;
      return row;
   endfunction

   function automatic stim_row_type chk_row(logic [TRU_OP_BITS-1:0] op, int r, int c,
                                            logic kind, logic [31:0] v, logic s);
      stim_row_type row;
      row                  = req_row(op, r, c, Q_ZERO);
      row.has_want         = 1'b1;
      row.want.result_kind = kind;
      row.want.entry_value = v;
      row.want.saturated   = s;
      return row;
   endfunction

   function automatic stim_row_type csr_row(tru_csr_type sel, logic [31:0] val);
      stim_row_type row;
      row         = req_row(OP_WRITE_X, 0, 0, Q_ZERO);
      row.is_csr  = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      return row;
   endfunction

   function automatic logic [31:0] rand_value();
      logic [31:0] v;
      case ($urandom_range(4))
         0: v = $urandom;
         1: begin
            case ($urandom_range(4))
               0: v = Q_TOP;
               1: v = Q_BOTTOM;
               2: v = Q_ZERO;
               3: v = Q_ONE;
               default: v = Q_NEG_ONE;
            endcase
         end
         default: v = $urandom_range(8 * 65536) - 4 * 65536;
      endcase
      return v;
   endfunction

   function automatic tru_req_item_type rand_req();
      int               pick;
      int               r;
      int               c;
      tru_req_item_type it;
      pick = $urandom_range(99);
      r    = $urandom_range(DIM - 1);
      c    = $urandom_range(DIM - 1);
      if (pick < 10) begin
         it = make_req(OP_WRITE_X, r, c, rand_value());
      end else if (pick < 20) begin
         it = make_req(OP_WRITE_Y, r, c, rand_value());
      end else if (pick < 45) begin
         it = make_req(OP_WRITE_A, r, c, rand_value());
      end else if (pick < 85) begin
         it = make_req(OP_READ, r, c, $urandom);
      end else if (pick < 93) begin
         it = make_req(OP_RUN, r, c, $urandom);
      end else begin
         it = make_req(TRU_OP_BITS'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), r, c, $urandom);
      end
      return it;
   endfunction

   // hold off until every awaited result has come back, then let the block settle
   task automatic drain();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(tru_csr_type sel, logic [31:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_ALPHA: cfg_alpha = longint'($signed(val));
         CSR_UPPER: cfg_upper = val[0];
         CSR_ROWS:  cfg_rows  = val[4:0];
         CSR_COLS:  cfg_cols  = val[4:0];
         default:   cfg_cols  = cfg_cols;
      endcase
      n_csr++;
   endtask

   task automatic issue(tru_req_item_type it, bit has_want, tru_rsp_item_type want);
      tru_rsp_item_type res;
      csr_valid <= 1'b0;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      n_beats++;
      if (step_request(it, res)) begin
         awaited_rsp.push_back(has_want ? want : res);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      tru_rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("unexpected result beat: kind %0b value %h sat %0b",
                        rsp_item.result_kind, rsp_item.entry_value, rsp_item.saturated);
            end
         end else begin
            want = awaited_rsp.pop_front();
            if (want.result_kind == RK_FINISH) n_runs++;
            else n_reads++;
            if (rsp_item.result_kind !== want.result_kind ||
                rsp_item.entry_value !== want.entry_value ||
                rsp_item.saturated   !== want.saturated) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("result mismatch: want kind %0b value %h sat %0b,",
                           want.result_kind, want.entry_value, want.saturated,
                           " got kind %0b value %h sat %0b",
                           rsp_item.result_kind, rsp_item.entry_value, rsp_item.saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      stim_row_type     plan [$];
      tru_rsp_item_type none;
      logic [31:0]      alpha_v;
      logic [31:0]      upper_v;
      logic [31:0]      rows_v;
      logic [31:0]      cols_v;
      int               p;
      int               k;

      none      = '0;
      cfg_alpha = TRU_ALPHA_RESET;
      cfg_upper = 1'b0;
      cfg_rows  = TRU_COUNT_BITS'(TRU_COUNT_RESET);
      cfg_cols  = TRU_COUNT_BITS'(TRU_COUNT_RESET);
      sat_seen  = 1'b0;
      foreach (a_mem[k]) a_mem[k] = 0;
      foreach (x_mem[k]) x_mem[k] = 0;
      foreach (y_mem[k]) y_mem[k] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(csr_row(CSR_ROWS, 32'd2));
      plan.push_back(csr_row(CSR_COLS, 32'd2));
      plan.push_back(req_row(OP_WRITE_X, 0, 0, Q_TOP));
      plan.push_back(req_row(OP_WRITE_X, 1, 0, Q_BOTTOM));
      plan.push_back(req_row(OP_WRITE_Y, 0, 0, Q_ONE));
      plan.push_back(req_row(OP_WRITE_Y, 0, 1, Q_NEG_ONE));
      plan.push_back(req_row(OP_WRITE_A, 0, 0, Q_TOP));
      plan.push_back(req_row(OP_WRITE_A, 0, 1, Q_ZERO));
      plan.push_back(req_row(OP_WRITE_A, 1, 0, Q_BOTTOM));
      plan.push_back(req_row(OP_WRITE_A, 1, 1, 32'h1234_5678));
      plan.push_back(chk_row(OP_READ, 0, 0, RK_READ, Q_TOP, 1'b0));
      plan.push_back(req_row(OP_WRITE_A, 15, 15, Q_BOTTOM));
      plan.push_back(chk_row(OP_READ, 15, 15, RK_READ, Q_BOTTOM, 1'b0));
      plan.push_back(req_row(OP_RSVD_LO, 15, 15, 32'hFFFF_FFFF));
      plan.push_back(req_row(OP_RSVD_HI, 0, 15, Q_TOP));
      plan.push_back(chk_row(OP_RUN, 0, 0, RK_FINISH, Q_ZERO, 1'b1));
      plan.push_back(req_row(OP_READ, 1, 0, Q_ZERO));
      plan.push_back(req_row(OP_READ, 1, 1, Q_ZERO));
      plan.push_back(csr_row(CSR_ALPHA, Q_BOTTOM));
      plan.push_back(csr_row(CSR_UPPER, 32'd1));
      plan.push_back(req_row(OP_RUN, 0, 0, Q_ZERO));
      plan.push_back(req_row(OP_READ, 0, 1, Q_ZERO));
      plan.push_back(csr_row(CSR_ROWS, 32'd0));
      plan.push_back(chk_row(OP_RUN, 0, 0, RK_FINISH, Q_ZERO, 1'b1));
      plan.push_back(req_row(OP_RSVD_MID, 15, 0, Q_BOTTOM));

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            csr_write(plan[k].csr_sel, plan[k].csr_val);
         end else begin
            issue(plan[k].req, plan[k].has_want, plan[k].want);
         end
      end

      // load every vector and matrix entry so later reads and runs see defined data
      for (k = 0; k < DIM; k++) begin
         issue(make_req(OP_WRITE_X, k, $urandom_range(DIM - 1), rand_value()), 1'b0, none);
         issue(make_req(OP_WRITE_Y, $urandom_range(DIM - 1), k, rand_value()), 1'b0, none);
      end
      for (k = 0; k < DIM * DIM; k++) begin
         issue(make_req(OP_WRITE_A, k / DIM, k % DIM, rand_value()), 1'b0, none);
      end

      for (p = 0; p < PHASES; p++) begin
         idle_pct = (p == 3 || p == 4) ? 0 : 16;
         case (p)
            0: begin
               alpha_v = Q_ONE;    upper_v = 32'd0; rows_v = 32'd16; cols_v = 32'd16;
            end
            1: begin
               alpha_v = Q_TOP;    upper_v = 32'd1; rows_v = 32'd31; cols_v = 32'd5;
            end
            2: begin
               alpha_v = Q_BOTTOM; upper_v = 32'd0; rows_v = 32'd3;  cols_v = 32'd31;
            end
            3: begin
               alpha_v = Q_ZERO;   upper_v = 32'd1; rows_v = 32'd1;  cols_v = 32'd16;
            end
            default: begin
               alpha_v = rand_value();
               upper_v = $urandom;
               rows_v  = ($urandom & 32'hFFFF_FFE0) |
                         (($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6));
               cols_v  = ($urandom & 32'hFFFF_FFE0) |
                         (($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6));
            end
         endcase
         csr_write(CSR_ALPHA, alpha_v);
         csr_write(CSR_UPPER, upper_v);
         csr_write(CSR_ROWS, rows_v);
         csr_write(CSR_COLS, cols_v);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            issue(rand_req(), 1'b0, none);
         end
      end

      drain();
      $display("checked %0d reads and %0d update runs out of %0d request beats",
               n_reads, n_runs, n_beats);
      $display("%0d register writes over %0d settings, %0d mismatches",
               n_csr, PHASES + 1, mismatches);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
